FILE: rtl/pira_pkg.sv
// Package for the positional insert / range minimum block.
// Holds field widths, item kind codes and the control bundle broadcast to the cells.
// No dependencies.
`default_nettype none
package pira_pkg;

  localparam int CAPACITY_DEF = 1024;

  localparam int VALUE_W = 31;   // signed element width
  localparam int FIELD_W = 11;   // position and range port width
  localparam int IDX_MAX_W = 17; // wide enough for any index up to 65536

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [IDX_MAX_W-1:0] idx_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic   shift;     // apply an insert this cycle
    idx_t   ins_pos;   // 0-based slot that receives the new value
    value_t ins_value;
    idx_t   lo;        // query window, 0-based, lo inclusive
    idx_t   hi;        // hi exclusive
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/pira_cell.sv
// One storage cell of the chain: holds a single element and one stage of the
// running-minimum wave. Depends on pira_pkg.
`default_nettype none
module pira_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pira_pkg::cell_ctrl_t ctrl,
  input  wire pira_pkg::value_t    left_val,
  input  wire pira_pkg::value_t    carry_in_min,
  input  wire logic                carry_in_vld,
  output pira_pkg::value_t         val,
  output pira_pkg::value_t         carry_out_min,
  output logic                     carry_out_vld
);

  localparam pira_pkg::idx_t MY_IDX = pira_pkg::IDX_MAX_W'(INDEX);

  logic in_rng;
  logic take_own;

  // Shift right behind the insert slot, load the new value at the slot.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      if (MY_IDX > ctrl.ins_pos) begin
        val <= left_val;
      end else if (MY_IDX == ctrl.ins_pos) begin
        val <= ctrl.ins_value;
      end
    end
  end

  assign in_rng   = (MY_IDX >= ctrl.lo) && (MY_IDX < ctrl.hi);
  assign take_own = in_rng && (!carry_in_vld || (val < carry_in_min));

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out_vld <= 1'b0;
    end else begin
      carry_out_vld <= carry_in_vld || in_rng;
    end
  end

  always_ff @(posedge clk) begin
    carry_out_min <= take_own ? val : carry_in_min;
  end

endmodule
`default_nettype wire

FILE: rtl/positional_insert_range_minimum.sv
// Top level of the positional insert / range minimum block.
// Depends on pira_pkg and pira_cell.
//
// The block keeps an ordered sequence of signed 31-bit values in a chain of
// CAPACITY cells, one element per cell. An item is taken when start is high
// and busy is low. Every item gives exactly one result, shown for one cycle
// with done high, and the receiver cannot stall it. An insert item (kind 0)
// puts value after the first "position" elements (a position past the length
// appends). Its result is registered in the S_INS state that follows the
// accept, and the next item can be accepted while done shows it. All cells
// behind the slot take their left neighbor's value at the edge that ends
// that done cycle. When the chain is full the insert is dropped and
// store_full is set. A query item (kind 1) returns the minimum of the
// 1-based range range_low..range_high, clipped to the length (a low of zero
// counts as one). The minimum travels as a wave through the chain, one cell
// per cycle, and the result is registered once sweep reaches CAPACITY. An
// empty range is answered from the S_QRY state without the sweep and is
// flagged by range_empty, with minimum zero. Insert results have minimum
// zero; store_full is zero on queries. After reset the sequence is empty;
// no clearing pass runs.
`default_nettype none
module positional_insert_range_minimum #(
  parameter int CAPACITY = pira_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                kind,
  input  wire logic [pira_pkg::FIELD_W-1:0]        position,
  input  wire logic signed [pira_pkg::VALUE_W-1:0] value,
  input  wire logic [pira_pkg::FIELD_W-1:0]        range_low,
  input  wire logic [pira_pkg::FIELD_W-1:0]        range_high,
  output logic                                     done,
  output logic signed [pira_pkg::VALUE_W-1:0]      minimum,
  output logic                                     range_empty,
  output logic                                     store_full
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_QRY  = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;     // stored elements
  logic [CNT_W-1:0] sweep;     // cycles the minimum wave has run
  logic             full_q;
  logic             empty_q;
  logic             shift_q;
  pira_pkg::idx_t   ins_pos_q;
  pira_pkg::value_t ins_value_q;
  pira_pkg::idx_t   lo_q;
  pira_pkg::idx_t   hi_q;

  pira_pkg::cell_ctrl_t ctrl;

  // Accept-time clipping of the item fields.
  logic             accept;
  pira_pkg::idx_t   count_ext;
  pira_pkg::idx_t   pos_ext;
  pira_pkg::idx_t   lo_ext;
  pira_pkg::idx_t   hi_ext;
  pira_pkg::idx_t   hi_clip;

  pira_pkg::value_t cell_val  [CAPACITY];
  pira_pkg::value_t carry_min [CAPACITY];
  logic             carry_vld [CAPACITY];

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign count_ext = pira_pkg::IDX_MAX_W'(count);
  assign pos_ext   = pira_pkg::IDX_MAX_W'(position);
  assign lo_ext    = (range_low == '0) ? pira_pkg::IDX_MAX_W'(1)
                                       : pira_pkg::IDX_MAX_W'(range_low);
  assign hi_ext    = pira_pkg::IDX_MAX_W'(range_high);
  assign hi_clip   = (hi_ext > count_ext) ? count_ext : hi_ext;

  // Latch the command for the cells; the shift strobe lasts one cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      ins_pos_q   <= (pos_ext > count_ext) ? count_ext : pos_ext;
      ins_value_q <= value;
      lo_q        <= lo_ext - pira_pkg::IDX_MAX_W'(1);
      hi_q        <= hi_clip;
      empty_q     <= lo_ext > hi_clip;
      full_q      <= count == CNT_W'(CAPACITY);
    end
  end

  always_comb begin
    ctrl.shift     = shift_q;
    ctrl.ins_pos   = ins_pos_q;
    ctrl.ins_value = ins_value_q;
    ctrl.lo        = lo_q;
    ctrl.hi        = hi_q;
  end

  // Sequencer: the S_INS state for an insert, a sweep of the chain for a query unless its range is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      sweep       <= '0;
      shift_q     <= 1'b0;
      done        <= 1'b0;
      minimum     <= '0;
      range_empty <= 1'b0;
      store_full  <= 1'b0;
    end else begin
      done    <= 1'b0;
      shift_q <= 1'b0;
      unique case (state)
        S_IDLE: begin
          sweep <= '0;
          if (accept) begin
            state <= (kind == pira_pkg::KIND_INSERT) ? S_INS : S_QRY;
          end
        end
        S_INS: begin
          // The cells shift on shift_q, registered here, unless the chain is full.
          shift_q     <= !full_q;
          done        <= 1'b1;
          minimum     <= '0;
          range_empty <= 1'b0;
          store_full  <= full_q;
          if (!full_q) begin
            count <= count + CNT_W'(1);
          end
          state <= S_IDLE;
        end
        S_QRY: begin
          // Wave has crossed the whole chain once sweep reaches CAPACITY.
          if (empty_q || (sweep == CNT_W'(CAPACITY))) begin
            done        <= 1'b1;
            minimum     <= empty_q ? '0 : carry_min[CAPACITY-1];
            range_empty <= empty_q;
            store_full  <= 1'b0;
            state       <= S_IDLE;
          end else begin
            sweep <= sweep + CNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Chain of cells: values shift right on insert, minimum wave runs left to right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      pira_cell #(.INDEX(i)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctrl         (ctrl),
        .left_val     (cell_val[0]),
        .carry_in_min ('0),
        .carry_in_vld (1'b0),
        .val          (cell_val[i]),
        .carry_out_min(carry_min[i]),
        .carry_out_vld(carry_vld[i])
      );
    end else begin : g_body
      pira_cell #(.INDEX(i)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctrl         (ctrl),
        .left_val     (cell_val[i-1]),
        .carry_in_min (carry_min[i-1]),
        .carry_in_vld (carry_vld[i-1]),
        .val          (cell_val[i]),
        .carry_out_min(carry_min[i]),
        .carry_out_vld(carry_vld[i])
      );
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pira_checker.sv
// Port-level checks for positional_insert_range_minimum, bound to the top level.
// Depends on pira_pkg.
`default_nettype none
module pira_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic                                kind,
  input wire logic                                done,
  input wire logic signed [pira_pkg::VALUE_W-1:0] minimum,
  input wire logic                                range_empty,
  input wire logic                                store_full
);

  // An accepted item holds the block busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result only follows a cycle of work.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a busy cycle");

  // Insert flags and query flags never show together.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(range_empty && store_full))
    else $error("range_empty and store_full both set");

  // An empty range or a dropped insert reports a zero minimum.
  a_flag_zero_min: assert property (@(posedge clk) disable iff (rst)
    done && (range_empty || store_full) |-> minimum == '0)
    else $error("flagged result with nonzero minimum");

  // An insert is never answered in the cycle right after its accept.
  a_insert_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (kind == pira_pkg::KIND_INSERT) |=> !done)
    else $error("insert result too early");

endmodule

bind positional_insert_range_minimum pira_checker u_pira_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .kind       (kind),
  .done       (done),
  .minimum    (minimum),
  .range_empty(range_empty),
  .store_full (store_full)
);
`default_nettype wire
